// ===== rtl/caseless_substring_search_macros.svh =====
// Assertion macros used by the top RTL file of the caseless substring search block.
`ifndef CASELESS_SUBSTRING_SEARCH_MACROS_SVH
`define CASELESS_SUBSTRING_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
`define CSS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("caseless_substring_search: assertion failed");
`define CSS_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("caseless_substring_search: reset assertion failed");
`else
`define CSS_ASSERT(label, prop)
`define CSS_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/css_pkg.sv =====
package css_pkg;

   localparam logic       MODE_PATTERN = 1'b0;
   localparam logic       MODE_TEXT    = 1'b1;
   localparam logic [7:0] NUL_BYTE     = 8'h00;
   localparam logic [7:0] LOWER_A      = 8'h61;
   localparam logic [7:0] LOWER_Z      = 8'h7a;
   localparam logic [7:0] FOLD_HIGH    = 8'hdf;
   localparam logic [7:0] CASE_BIT     = 8'h20;
   localparam int         POS_W        = 16;
   localparam logic [POS_W-1:0] POS_MAX = 16'hffff;

   typedef struct packed {
      logic load_en;
      logic text_en;
      logic clear;
   } cell_ctrl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= LOWER_A && c <= LOWER_Z) || c > FOLD_HIGH) begin
         r = c - CASE_BIT;
      end
      return r;
   endfunction

endpackage

// ===== rtl/css_cell.sv =====
module css_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  css_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             pattern_byte,
   input  logic [7:0]             text_fold,
   input  logic                   prev_match,
   output logic                   match_next,
   output logic                   match_q
);
   import css_pkg::*;

   logic [7:0] pat_ff;
   logic [7:0] pat_in;
   logic       match_ff;
   logic       match_in;

   // The cell keeps its pattern byte already folded, so only one fold sits on the text path.
   always_comb begin
      pat_in     = ctrl.load_en ? fold_case(pattern_byte) : pat_ff;
      match_next = prev_match && (text_fold == pat_ff);
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.text_en) begin
         match_in = match_next;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_q = match_ff;

endmodule

// ===== rtl/caseless_substring_search.sv =====
// Caseless substring search over a stream of byte requests.
// Request channel: req_valid/req_ready with req_mode (0 pattern, 1 text) and req_char_byte.
// Pattern bytes load a row of MAX_PATTERN compare cells; a zero pattern byte closes the
// pattern, and the next pattern byte starts a new one. Text bytes are folded to upper case
// and broadcast to every cell; cell k remembers whether the text so far ends in the first
// k+1 pattern bytes and passes that bit to cell k+1 on the next text byte.
// A zero text byte ends the text and produces one response on rsp_valid/rsp_ready with
// found, match_position (earliest start), pattern_error and text_overflow.
// One request is accepted per cycle, set by the single step of the cell chain, except that
// a terminating text byte waits while a response is held. The response is registered and
// appears the cycle after the terminating request is accepted.
// While a response waits and rsp_ready is low, pattern and text bytes are still accepted;
// only the next terminating text byte is held off until the response is taken.
// Reset (synchronous) clears the pattern length, all match bits, counters and the response
// valid flag; response fields and pattern bytes in the cells are undefined until written.
`include "caseless_substring_search_macros.svh"

module caseless_substring_search #(
   parameter int MAX_PATTERN       = 64,
   parameter int MAX_TEXT_POSITION = 65535
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [7:0]                  req_char_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [css_pkg::POS_W-1:0]   rsp_match_position,
   output logic                        rsp_pattern_error,
   output logic                        rsp_text_overflow
);
   import css_pkg::*;

   localparam int LW  = $clog2(MAX_PATTERN + 1);
   localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CW  = $clog2(MAX_TEXT_POSITION + 1);
   localparam int SW0 = (CW > LW) ? CW : LW;
   localparam int SW  = (SW0 > POS_W) ? SW0 : POS_W;

   logic [LW-1:0]      len_ff, len_in;
   logic               closed_ff, closed_in;
   logic               too_long_ff, too_long_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               seen_ff, seen_in;
   logic [POS_W-1:0]   first_ff, first_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               perr_ff, perr_in;
   logic               tovf_ff, tovf_in;

   logic               fire;
   logic               is_term;
   logic               pat_fire;
   logic               text_fire;
   logic               term_fire;
   logic               search_en;
   logic               clear_text;
   logic [LW-1:0]      eff_len;
   logic [LW-1:0]      len_m1;
   logic               hit;
   logic [SW-1:0]      start_pos;
   logic [7:0]         text_fold;
   logic [MAX_PATTERN-1:0] match_next;
   logic [MAX_PATTERN-1:0] match_q;
   cell_ctrl_type      ctrl [MAX_PATTERN];

   assign is_term   = (req_mode == MODE_TEXT) && (req_char_byte == NUL_BYTE);
   assign req_ready = !is_term || !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign pat_fire  = fire && (req_mode == MODE_PATTERN);
   assign text_fire = fire && (req_mode == MODE_TEXT) && !is_term;
   assign term_fire = fire && is_term;
   assign search_en = text_fire && (count_ff < CW'(MAX_TEXT_POSITION));
   assign clear_text = pat_fire || term_fire;
   assign eff_len   = closed_ff ? '0 : len_ff;
   assign text_fold = fold_case(req_char_byte);
   assign len_m1    = len_ff - LW'(1);
   assign hit       = match_next[len_m1[IW-1:0]];
   assign start_pos = SW'(count_ff) + SW'(1) - SW'(len_ff);

   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         assign ctrl[k].load_en = pat_fire && (req_char_byte != NUL_BYTE)
                                  && (eff_len == LW'(k));
         assign ctrl[k].text_en = search_en;
         assign ctrl[k].clear   = clear_text;
         css_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl[k]),
            .pattern_byte (req_char_byte),
            .text_fold    (text_fold),
            .prev_match   ((k == 0) ? 1'b1 : match_q[(k == 0) ? 0 : k - 1]),
            .match_next   (match_next[k]),
            .match_q      (match_q[k])
         );
      end
   endgenerate

   always_comb begin
      len_in       = len_ff;
      closed_in    = closed_ff;
      too_long_in  = too_long_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      pos_in       = pos_ff;
      perr_in      = perr_ff;
      tovf_in      = tovf_ff;

      if (pat_fire) begin
         len_in      = eff_len;
         too_long_in = closed_ff ? 1'b0 : too_long_ff;
         closed_in   = 1'b0;
         if (req_char_byte == NUL_BYTE) begin
            closed_in = 1'b1;
         end else if (eff_len < LW'(MAX_PATTERN)) begin
            len_in = eff_len + LW'(1);
         end else begin
            too_long_in = 1'b1;
         end
      end

      if (text_fire) begin
         if (!search_en) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
            if (!seen_ff) begin
               if (len_ff == '0) begin
                  seen_in  = 1'b1;
                  first_in = '0;
               end else if (hit) begin
                  seen_in  = 1'b1;
                  first_in = (start_pos > SW'(POS_MAX)) ? POS_MAX : start_pos[POS_W-1:0];
               end
            end
         end
      end

      if (term_fire) begin
         rsp_valid_in = 1'b1;
         found_in     = seen_ff && !too_long_ff;
         pos_in       = (seen_ff && !too_long_ff) ? first_ff : '0;
         perr_in      = too_long_ff;
         tovf_in      = ovf_ff;
      end

      if (clear_text) begin
         count_in = '0;
         seen_in  = 1'b0;
         first_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pos_ff   <= pos_in;
      perr_ff  <= perr_in;
      tovf_ff  <= tovf_in;
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b0;
         too_long_ff  <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         first_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         too_long_ff  <= too_long_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_match_position = pos_ff;
   assign rsp_pattern_error  = perr_ff;
   assign rsp_text_overflow  = tovf_ff;

   `CSS_ASSERT(a_len_bound, len_ff <= LW'(MAX_PATTERN))
   `CSS_ASSERT(a_count_bound, count_ff <= CW'(MAX_TEXT_POSITION))
   `CSS_ASSERT(a_ovf_at_limit, ovf_ff |-> (count_ff == CW'(MAX_TEXT_POSITION)))
   `CSS_ASSERT(a_found_no_error, rsp_valid_ff |-> !(found_ff && perr_ff))
   `CSS_ASSERT(a_term_clears, term_fire |=> (count_ff == '0) && !seen_ff && !ovf_ff)
   `CSS_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid_ff && (len_ff == '0))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import css_pkg::*;

   localparam int PATTERN_SLOTS = 64;
   localparam int TEXT_LIMIT    = 65535;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [7:0] UPPER_A          = 8'h41;
   localparam logic [7:0] UPPER_Z          = 8'h5a;
   localparam logic [7:0] HIGH_UPPER_FIRST = 8'hc0;

   typedef struct {
      bit               found;
      logic [POS_W-1:0] position;
      bit               pattern_error;
      bit               text_overflow;
   } search_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = MODE_PATTERN;
   logic [7:0]       req_char_byte = NUL_BYTE;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic [POS_W-1:0] rsp_match_position;
   logic             rsp_pattern_error;
   logic             rsp_text_overflow;

   logic [7:0]  pat_bytes [PATTERN_SLOTS];
   int unsigned pat_len;
   bit          pat_closed;
   bit          pat_overrun;
   logic [7:0]  text_ring [PATTERN_SLOTS];
   int unsigned text_len;
   bit          hit_seen;
   int unsigned hit_start;
   bit          text_capped;

   search_result_type expected_results[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int requests_sent = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   caseless_substring_search #(
      .MAX_PATTERN       (PATTERN_SLOTS),
      .MAX_TEXT_POSITION (TEXT_LIMIT)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_char_byte      (req_char_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_match_position (rsp_match_position),
      .rsp_pattern_error  (rsp_pattern_error),
      .rsp_text_overflow  (rsp_text_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] upper_fold(input logic [7:0] c);
      if ((c >= LOWER_A && c <= LOWER_Z) || c > FOLD_HIGH) begin
         return c - CASE_BIT;
      end
      return c;
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] c);
      logic [7:0] other;
      if ((c >= LOWER_A && c <= LOWER_Z) || c > FOLD_HIGH) begin
         other = c - CASE_BIT;
      end else if ((c >= UPPER_A && c <= UPPER_Z) || (c >= HIGH_UPPER_FIRST && c <= FOLD_HIGH)) begin
         other = c + CASE_BIT;
      end else begin
         other = c;
      end
      return ($urandom_range(1) == 1) ? other : c;
   endfunction

   function automatic void clear_text_state();
      foreach (text_ring[i]) text_ring[i] = NUL_BYTE;
      text_len    = 0;
      hit_seen    = 1'b0;
      hit_start   = 0;
      text_capped = 1'b0;
   endfunction

   function automatic void clear_search_state();
      foreach (pat_bytes[i]) pat_bytes[i] = NUL_BYTE;
      pat_len     = 0;
      pat_closed  = 1'b0;
      pat_overrun = 1'b0;
      clear_text_state();
   endfunction

   function automatic void absorb_text_byte(input logic [7:0] c);
      int unsigned idx;
      int unsigned start;
      bit          hit;
      if (text_len >= TEXT_LIMIT) begin
         text_capped = 1'b1;
         return;
      end
      idx = text_len;
      text_ring[idx % PATTERN_SLOTS] = c;
      text_len = idx + 1;
      if (hit_seen) return;
      if (pat_len == 0) begin
         hit_seen  = 1'b1;
         hit_start = 0;
         return;
      end
      if (idx + 1 < pat_len) return;
      start = idx + 1 - pat_len;
      hit   = 1'b1;
      for (int k = 0; k < pat_len; k++) begin
         if (upper_fold(text_ring[(start + k) % PATTERN_SLOTS]) != upper_fold(pat_bytes[k])) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         hit_seen  = 1'b1;
         hit_start = start;
      end
   endfunction

   function automatic void predict_request(input logic m, input logic [7:0] c);
      search_result_type r;
      if (m == MODE_PATTERN) begin
         clear_text_state();
         if (pat_closed) begin
            pat_len     = 0;
            pat_overrun = 1'b0;
            pat_closed  = 1'b0;
         end
         if (c == NUL_BYTE) begin
            pat_closed = 1'b1;
         end else if (pat_len < PATTERN_SLOTS) begin
            pat_bytes[pat_len] = c;
            pat_len++;
         end else begin
            pat_overrun = 1'b1;
         end
      end else if (c != NUL_BYTE) begin
         absorb_text_byte(c);
      end else begin
         r.pattern_error = pat_overrun;
         r.text_overflow = text_capped;
         r.found         = hit_seen && !pat_overrun;
         if (r.found) begin
            r.position = (hit_start > POS_MAX) ? POS_MAX : hit_start[POS_W-1:0];
         end else begin
            r.position = '0;
         end
         expected_results.push_back(r);
         clear_text_state();
      end
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch on %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   always @(posedge clock) begin
      search_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("response with none pending", 0, 1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_found !== want.found)
                  note_mismatch("found", want.found, rsp_found);
               if (rsp_match_position !== want.position)
                  note_mismatch("match_position", want.position, rsp_match_position);
               if (rsp_pattern_error !== want.pattern_error)
                  note_mismatch("pattern_error", want.pattern_error, rsp_pattern_error);
               if (rsp_text_overflow !== want.text_overflow)
                  note_mismatch("text_overflow", want.text_overflow, rsp_text_overflow);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic m, input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_char_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(m, c);
      requests_sent++;
   endtask

   task automatic send_string(input logic m, input string s);
      for (int i = 0; i < s.len(); i++) send_request(m, s[i]);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic [7:0] pick_letter();
      logic [7:0] common [8] = '{"a", "A", "b", "B", 8'he1, 8'hc1, 8'hff, 8'hdf};
      if ($urandom_range(1) == 1) return 8'($urandom_range(255, 1));
      return common[$urandom_range(7)];
   endfunction

   function automatic logic [7:0] text_char();
      if (pat_len > 0 && $urandom_range(1) == 1) begin
         return vary_case(pat_bytes[$urandom_range(pat_len - 1)]);
      end
      return vary_case(pick_letter());
   endfunction

   task automatic send_random_pattern();
      int count;
      count = ($urandom_range(9) == 0) ? $urandom_range(70, 56) : $urandom_range(6);
      repeat (count) send_request(MODE_PATTERN, pick_letter());
      if ($urandom_range(9) != 0) send_request(MODE_PATTERN, NUL_BYTE);
   endtask

   task automatic send_random_text();
      int count;
      count = $urandom_range(30);
      for (int i = 0; i < count; i++) begin
         if (pat_len > 0 && $urandom_range(4) == 0) begin
            for (int k = 0; k < pat_len; k++) send_request(MODE_TEXT, vary_case(pat_bytes[k]));
         end else begin
            send_request(MODE_TEXT, text_char());
         end
      end
      send_request(MODE_TEXT, NUL_BYTE);
   endtask

   task automatic test_empty_strings();
      send_request(MODE_TEXT, NUL_BYTE);
      send_request(MODE_TEXT, 8'h01);
      send_request(MODE_TEXT, NUL_BYTE);
      send_request(MODE_TEXT, 8'hff);
      send_request(MODE_TEXT, 8'h80);
      send_request(MODE_TEXT, NUL_BYTE);
      send_request(MODE_PATTERN, NUL_BYTE);
      send_request(MODE_PATTERN, NUL_BYTE);
      send_string(MODE_TEXT, "Q");
      send_request(MODE_TEXT, NUL_BYTE);
   endtask

   task automatic test_case_folding();
      send_string(MODE_PATTERN, "aZ");
      send_request(MODE_PATTERN, 8'he0);
      send_request(MODE_PATTERN, 8'hdf);
      send_request(MODE_PATTERN, NUL_BYTE);
      send_string(MODE_TEXT, "{Az");
      send_request(MODE_TEXT, 8'hc0);
      send_request(MODE_TEXT, 8'hff);
      send_request(MODE_TEXT, NUL_BYTE);
      send_string(MODE_PATTERN, "@[");
      send_request(MODE_PATTERN, NUL_BYTE);
      send_string(MODE_TEXT, "`{");
      send_request(MODE_TEXT, NUL_BYTE);
      send_string(MODE_PATTERN, "m");
      send_request(MODE_PATTERN, NUL_BYTE);
      send_string(MODE_TEXT, "mM");
      send_request(MODE_TEXT, NUL_BYTE);
   endtask

   task automatic test_open_pattern_and_abandoned_text();
      send_string(MODE_PATTERN, "ab");
      send_string(MODE_TEXT, "xAB");
      send_string(MODE_PATTERN, "c");
      send_string(MODE_TEXT, "zABc");
      send_request(MODE_TEXT, NUL_BYTE);
      send_request(MODE_PATTERN, NUL_BYTE);
   endtask

   task automatic test_pattern_length_limit();
      for (int i = 0; i < PATTERN_SLOTS; i++) send_request(MODE_PATTERN, 8'(i * 4 + 3));
      send_request(MODE_PATTERN, NUL_BYTE);
      send_string(MODE_TEXT, "q");
      for (int i = 0; i < PATTERN_SLOTS; i++) send_request(MODE_TEXT, vary_case(8'(i * 4 + 3)));
      send_request(MODE_TEXT, NUL_BYTE);
      for (int i = 0; i < PATTERN_SLOTS; i++) send_request(MODE_PATTERN, 8'(i * 4 + 3));
      send_string(MODE_PATTERN, "e");
      send_request(MODE_PATTERN, NUL_BYTE);
      for (int i = 0; i < PATTERN_SLOTS; i++) send_request(MODE_TEXT, 8'(i * 4 + 3));
      send_request(MODE_TEXT, NUL_BYTE);
   endtask

   task automatic test_random_sequences(input int quota);
      int stop_at;
      int pick;
      int count;
      stop_at = requests_sent + quota;
      hold_until_drained();
      while (requests_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            count = $urandom_range(4, 1);
            repeat (count) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
         end else if (pick < 22) begin
            send_random_pattern();
         end else if (pick < 27) begin
            count = $urandom_range(6, 1);
            repeat (count) send_request(MODE_TEXT, text_char());
            send_request(MODE_PATTERN, pick_letter());
         end else if (pick < 29) begin
            hold_until_drained();
         end else begin
            send_random_text();
         end
      end
   endtask

   initial begin
      clear_search_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 70;
      test_empty_strings();
      test_case_folding();
      test_open_pattern_and_abandoned_text();
      test_pattern_length_limit();
      test_random_sequences(350);

      send_idle_pct = 70;
      recv_idle_pct = 37;
      test_random_sequences(350);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sequences(350);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/css_pkg.sv
rtl/css_cell.sv
rtl/caseless_substring_search.sv
tb/tb_top.sv
